// ===== design/tpbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texture sampler package
// Shared types, constants and the channel blend function.
// ----------------------------------------------------------------------------
package tpbs_pkg;

    localparam int FracBits   = 16;
    localparam int AddrBits   = 16;
    localparam int RegBits    = 13;
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = 2;

    localparam logic [1:0] OP_WRITE    = 2'd0;
    localparam logic [1:0] OP_POINT    = 2'd1;
    localparam logic [1:0] OP_BILINEAR = 2'd2;

    localparam logic [1:0] CFG_SCALE_X   = 2'd0;
    localparam logic [1:0] CFG_SCALE_Y   = 2'd1;
    localparam logic [1:0] CFG_ROW_PITCH = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] u_coord;
        logic [15:0] v_coord;
        logic [15:0] texel_address;
        logic [31:0] texel_value;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out_beat;

    // One classified beat travelling from the front to the back. A write
    // uses addr00 as its store address.
    typedef struct packed {
        logic                wr;
        logic [31:0]         wr_data;
        logic                bilinear;
        logic [AddrBits-1:0] addr00;
        logic [AddrBits-1:0] addr01;
        logic [AddrBits-1:0] addr10;
        logic [AddrBits-1:0] addr11;
        logic [FracBits-1:0] frac_x;
        logic [FracBits-1:0] frac_y;
    } t_sample;

    // Floor blend a + floor((b - a) * f / 2^FracBits).
    function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                         input logic [FracBits-1:0] f);
        logic signed [8:0]            d;
        logic signed [FracBits+9:0]   p;
        logic signed [9:0]            s;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        p = d * $signed({1'b0, f});
        s = 10'(p >>> FracBits);
        return 8'($signed({2'b00, a}) + s);
    endfunction

endpackage

// ===== design/tpbs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texture sampler front end
// Takes input beats, passes writes on in order and turns samples into four
// addresses.
// ----------------------------------------------------------------------------
module tpbs_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  tpbs_pkg::t_in_beat             i_beat,
    input  logic [tpbs_pkg::RegBits-1:0]   i_scale_x,
    input  logic [tpbs_pkg::RegBits-1:0]   i_scale_y,
    input  logic [tpbs_pkg::RegBits-1:0]   i_row_pitch,
    input  logic                           i_space,
    output logic                           o_push,
    output tpbs_pkg::t_sample              o_sample
);
    logic        r_v1;
    logic        r_bil;
    logic        r_wr;
    logic [tpbs_pkg::AddrBits-1:0] r_waddr;
    logic [31:0] r_wdata;
    logic [28:0] r_tx;
    logic [28:0] r_ty;
    logic [tpbs_pkg::RegBits-1:0] r_pitch;
    logic        r_v2;
    logic        r_bil2;
    logic        r_wr2;
    logic [31:0] r_wdata2;
    logic [tpbs_pkg::AddrBits-1:0] r_base;
    logic [tpbs_pkg::AddrBits-1:0] r_pitch2;
    logic [tpbs_pkg::FracBits-1:0] r_fx;
    logic [tpbs_pkg::FracBits-1:0] r_fy;
    logic        adv;
    logic        is_sample;
    logic        is_write;
    logic [25:0] row_prod;

    assign adv       = !r_v2 || i_space;
    assign o_ready   = adv;
    assign is_sample = (i_beat.operation == tpbs_pkg::OP_POINT) ||
                       (i_beat.operation == tpbs_pkg::OP_BILINEAR);
    assign is_write  = i_beat.operation == tpbs_pkg::OP_WRITE;
    assign row_prod  = r_ty[28:16] * r_pitch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid && (is_sample || is_write);
            r_v2 <= r_v1;
        end
        if (adv) begin
            r_bil    <= i_beat.operation == tpbs_pkg::OP_BILINEAR;
            r_wr     <= is_write;
            r_waddr  <= i_beat.texel_address;
            r_wdata  <= i_beat.texel_value;
            r_tx     <= i_beat.u_coord * i_scale_x;
            r_ty     <= i_beat.v_coord * i_scale_y;
            r_pitch  <= i_row_pitch;
            r_bil2   <= r_bil;
            r_wr2    <= r_wr;
            r_wdata2 <= r_wdata;
            r_base   <= r_wr ? r_waddr : 16'(row_prod) + 16'(r_tx[28:16]);
            r_pitch2 <= 16'(r_pitch);
            r_fx     <= r_tx[15:0];
            r_fy     <= r_ty[15:0];
        end
    end

    assign o_push = r_v2 && i_space;
    assign o_sample.wr       = r_wr2;
    assign o_sample.wr_data  = r_wdata2;
    assign o_sample.bilinear = r_bil2;
    assign o_sample.addr00   = r_base;
    assign o_sample.addr01   = r_base + 16'd1;
    assign o_sample.addr10   = r_base + r_pitch2;
    assign o_sample.addr11   = r_base + r_pitch2 + 16'd1;
    assign o_sample.frac_x   = r_fx;
    assign o_sample.frac_y   = r_fy;
endmodule

// ===== design/tpbs_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texture sampler request queue
// Small FIFO of classified samples between front and back.
// ----------------------------------------------------------------------------
module tpbs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tpbs_pkg::t_sample i_data,
    output logic              o_space,
    input  logic              i_pop,
    output logic              o_valid,
    output tpbs_pkg::t_sample o_data
);
    tpbs_pkg::t_sample r_mem [tpbs_pkg::QueueDepth];
    logic [tpbs_pkg::QueuePtrW-1:0] r_wp;
    logic [tpbs_pkg::QueuePtrW-1:0] r_rp;
    logic [tpbs_pkg::QueuePtrW:0]   r_cnt;

    assign o_space = r_cnt != 3'(tpbs_pkg::QueueDepth);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule

// ===== design/tpbs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texture sampler back end
// Four texel banks read in parallel, a horizontal blend stage and an output
// register that holds the vertical blend.
// ----------------------------------------------------------------------------
module tpbs_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  tpbs_pkg::t_sample              i_q_data,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output tpbs_pkg::t_out_beat            o_beat
);
    // Four copies of the store give four read ports.
    logic [31:0] r_mem0 [1<<tpbs_pkg::AddrBits];
    logic [31:0] r_mem1 [1<<tpbs_pkg::AddrBits];
    logic [31:0] r_mem2 [1<<tpbs_pkg::AddrBits];
    logic [31:0] r_mem3 [1<<tpbs_pkg::AddrBits];
    logic [31:0] r_t00, r_t01, r_t10, r_t11;
    logic        r_v1, r_bil1;
    logic [tpbs_pkg::FracBits-1:0] r_fx1, r_fy1;
    logic        r_v2, r_bil2;
    logic [31:0] r_top, r_bot, r_pt;
    logic [tpbs_pkg::FracBits-1:0] r_fy2;
    logic        r_ov;
    tpbs_pkg::t_out_beat r_out;
    logic        adv;
    logic [31:0] n_top, n_bot, n_res;

    assign adv   = !r_ov || i_ready;
    assign o_pop = adv && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_data.wr) begin
            r_mem0[i_q_data.addr00] <= i_q_data.wr_data;
            r_mem1[i_q_data.addr00] <= i_q_data.wr_data;
            r_mem2[i_q_data.addr00] <= i_q_data.wr_data;
            r_mem3[i_q_data.addr00] <= i_q_data.wr_data;
        end
        if (adv) begin
            r_t00 <= r_mem0[i_q_data.addr00];
            r_t01 <= r_mem1[i_q_data.addr01];
            r_t10 <= r_mem2[i_q_data.addr10];
            r_t11 <= r_mem3[i_q_data.addr11];
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_top[8*k +: 8] = tpbs_pkg::blend(r_t00[8*k +: 8], r_t01[8*k +: 8], r_fx1);
            n_bot[8*k +: 8] = tpbs_pkg::blend(r_t10[8*k +: 8], r_t11[8*k +: 8], r_fx1);
            n_res[8*k +: 8] = tpbs_pkg::blend(r_top[8*k +: 8], r_bot[8*k +: 8], r_fy2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_q_valid && !i_q_data.wr;
            r_v2 <= r_v1;
            r_ov <= r_v2;
        end
        if (adv) begin
            r_bil1 <= i_q_data.bilinear;
            r_fx1  <= i_q_data.frac_x;
            r_fy1  <= i_q_data.frac_y;
            r_bil2 <= r_bil1;
            r_top  <= n_top;
            r_bot  <= n_bot;
            r_pt   <= r_t00;
            r_fy2  <= r_fy1;
            r_out  <= r_bil2 ? n_res : r_pt;
        end
    end

    assign o_valid = r_ov;
    assign o_beat  = r_out;
endmodule

// ===== design/texture_point_bilinear_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texture point and bilinear sampler
// Top level: configuration registers, front end, queue and back end.
// ----------------------------------------------------------------------------
// One beat is accepted per cycle, writes and samples alike, as long as
// results are taken. A sample passes two front stages that compute the
// address, then the queue, then a texel read from four store copies, a
// horizontal blend stage and the output register that holds the vertical
// blend. A write travels the same path and updates the store when it leaves
// the queue, so every sample sees exactly the writes accepted before it.
module texture_point_bilinear_sampler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  tpbs_pkg::t_in_beat            i_beat,
    output logic                          o_valid,
    input  logic                          i_ready,
    output tpbs_pkg::t_out_beat           o_beat,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [tpbs_pkg::RegBits-1:0]  i_cfg_data
);
    logic [tpbs_pkg::RegBits-1:0] r_scale_x, r_scale_y, r_row_pitch;
    logic push, space, pop, q_valid;
    tpbs_pkg::t_sample sample, q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x   <= '0;
            r_scale_y   <= '0;
            r_row_pitch <= 13'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tpbs_pkg::CFG_SCALE_X:   r_scale_x   <= i_cfg_data;
                tpbs_pkg::CFG_SCALE_Y:   r_scale_y   <= i_cfg_data;
                tpbs_pkg::CFG_ROW_PITCH: r_row_pitch <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tpbs_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_beat,
        .i_scale_x(r_scale_x), .i_scale_y(r_scale_y), .i_row_pitch(r_row_pitch),
        .i_space(space), .o_push(push), .o_sample(sample)
    );

    tpbs_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_data(sample), .o_space(space),
        .i_pop(pop), .o_valid(q_valid), .o_data(q_data)
    );

    tpbs_back u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(q_valid), .i_q_data(q_data), .o_pop(pop),
        .o_valid, .i_ready, .o_beat
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> space) else $error("queue overflow");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid) else $error("queue underflow");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_beat)) else $error("result dropped");
`endif
endmodule
